// File: design/packbits_rle_decoder_top_defines.svh
// assertion macros for the packbits run-length decoder
// used by packbits_rle_decoder_top, expects clk and rst in scope
`ifndef PACKBITS_RLE_DECODER_TOP_DEFINES_SVH
`define PACKBITS_RLE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBRLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbrle check failed");

// next-cycle implication, checked outside reset
`define PBRLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbrle check failed");

`endif

// File: design/pbrle_pkg.sv
// shared types and constants of the packbits run-length decoder
// no dependencies
package pbrle_pkg;

  localparam int LANE_W    = 8;
  localparam int OUT_LANES = 8;
  localparam int OUT_W     = LANE_W * OUT_LANES;
  localparam int CNT_W     = 4;
  localparam int LEFT_W    = 8;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // front decode modes
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_RUN     = 2'd2;

  localparam logic [LANE_W-1:0] HDR_NOP  = 8'h80;
  localparam logic [LANE_W:0]   RUN_BASE = 9'd257;

  // one unit of work for the back end: repeat data count times
  typedef struct packed {
    logic [LANE_W-1:0] data;
    logic [LEFT_W-1:0] count;
  } pbrle_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pbrle_qstat_t;

endpackage

// File: design/packbits_rle_decoder_top.sv
// Packbits run-length decoder. One compressed byte is accepted per cycle
// while full is low; header bytes and the data byte of a zero-length run
// (header 0x80) give no result, each literal byte gives one single-byte
// result, and the data byte of a run of n copies gives ceil(n/8) results
// of up to eight packed bytes, all full but the last. The back end sends
// one result per cycle from its output register while the consumer pops,
// so literal streams run at one byte per cycle under that condition; a run
// occupies the back end for its ceil(n/8) results while the front end keeps taking
// bytes into a four-entry command queue, and full rises once that queue
// fills. No clearing pass is needed after reset.
// depends on pbrle_pkg, pbrle_front, pbrle_queue, pbrle_back and the defines header
`include "packbits_rle_decoder_top_defines.svh"

module packbits_rle_decoder_top import pbrle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [LANE_W-1:0]  in_byte,
  output logic               empty,
  input  logic               pop,
  output logic [OUT_W-1:0]   out_bytes,
  output logic [CNT_W-1:0]   byte_count,
  output logic               last_of_run
);

  logic         accept;
  logic         wr_valid;
  pbrle_cmd_t   wr_cmd;
  pbrle_cmd_t   head;
  pbrle_qstat_t qstat;
  logic         rd_pop;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  pbrle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .wr_valid (wr_valid),
    .wr_cmd   (wr_cmd)
  );

  pbrle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_cmd   (wr_cmd),
    .rd_pop   (rd_pop),
    .rd_cmd   (head),
    .stat     (qstat)
  );

  pbrle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .rd_pop      (rd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_bytes   (out_bytes),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

  // a shown beat always carries one to eight bytes
  `PBRLE_ASSERT_NOW(a_count_range, !empty, (byte_count != '0) && (byte_count <= CNT_W'(OUT_LANES)))
  // every beat of a run but the last is full and packed with one byte value
  `PBRLE_ASSERT_NOW(a_mid_run_full, !empty && !last_of_run, (byte_count == CNT_W'(OUT_LANES)) && (out_bytes[LANE_W-1:0] == out_bytes[OUT_W-1 -: LANE_W]))
  // the back end only drains the queue when a beat is being loaded
  `PBRLE_ASSERT_NEXT(a_pop_loads, rd_pop, !empty)

endmodule

// File: design/pbrle_front.sv
// front end: tracks header / literal / run state and turns input beats into commands
// depends on pbrle_pkg
module pbrle_front import pbrle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [LANE_W-1:0] in_byte,
  output logic              wr_valid,
  output pbrle_cmd_t        wr_cmd
);

  logic [1:0]        mode, mode_next;
  logic [LEFT_W-1:0] bytes_left, bytes_left_next;

  always_comb begin
    mode_next       = mode;
    bytes_left_next = bytes_left;
    wr_valid        = 1'b0;
    wr_cmd.data     = in_byte;
    wr_cmd.count    = LEFT_W'(1);
    if (accept) begin
      unique case (mode)
        MODE_LITERAL: begin
          wr_valid        = 1'b1;
          bytes_left_next = bytes_left - LEFT_W'(1);
          if (bytes_left_next == '0) begin
            mode_next = MODE_HEADER;
          end
        end
        MODE_RUN: begin
          // zero-length run from header 0x80 swallows its data byte
          wr_valid        = (bytes_left != '0);
          wr_cmd.count    = bytes_left;
          bytes_left_next = '0;
          mode_next       = MODE_HEADER;
        end
        default: begin
          if (!in_byte[LANE_W-1]) begin
            mode_next       = MODE_LITERAL;
            bytes_left_next = in_byte + LEFT_W'(1);
          end else begin
            mode_next = MODE_RUN;
            if (in_byte == HDR_NOP) begin
              bytes_left_next = '0;
            end else begin
              bytes_left_next = LEFT_W'(RUN_BASE - {1'b0, in_byte});
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_HEADER;
      bytes_left <= '0;
    end else begin
      mode       <= mode_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// File: design/pbrle_queue.sv
// small command fifo that decouples the front end from the back end
// depends on pbrle_pkg
module pbrle_queue import pbrle_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  input  pbrle_cmd_t   wr_cmd,
  input  logic         rd_pop,
  output pbrle_cmd_t   rd_cmd,
  output pbrle_qstat_t stat
);

  pbrle_cmd_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr, do_rd;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign do_wr      = wr_valid && !stat.full;
  assign do_rd      = rd_pop && !stat.empty;
  assign rd_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/pbrle_back.sv
// back end: expands commands into packed result beats and holds the output register
// depends on pbrle_pkg
module pbrle_back import pbrle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pbrle_cmd_t         head,
  input  pbrle_qstat_t       qstat,
  output logic               rd_pop,
  input  logic               pop,
  output logic               empty,
  output logic [OUT_W-1:0]   out_bytes,
  output logic [CNT_W-1:0]   byte_count,
  output logic               last_of_run
);

  logic              out_valid;
  logic              busy;
  logic [LEFT_W-1:0] cur_left;
  logic [LEFT_W-1:0] left, rem;
  logic [CNT_W-1:0]  take;
  logic              out_load, step;
  logic [OUT_W-1:0]  lanes;

  assign empty    = !out_valid;
  assign out_load = !out_valid || pop;
  assign step     = out_load && (busy || !qstat.empty);

  // busy means the head command is partly sent and cur_left copies remain
  assign left = busy ? cur_left : head.count;
  assign take = (left > LEFT_W'(OUT_LANES)) ? CNT_W'(OUT_LANES) : left[CNT_W-1:0];
  assign rem  = left - LEFT_W'(take);

  assign rd_pop = step && (rem == '0);

  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      lanes[i*LANE_W +: LANE_W] = (CNT_W'(i) < take) ? head.data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_bytes   <= lanes;
      byte_count  <= take;
      last_of_run <= (rem == '0);
      cur_left    <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        busy      <= (rem != '0);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
